FILE: rtl/core/fsfr_pkg.sv
// shared types, codes and the crc-8/maxim byte update for the fuel sensor frame receiver
// no dependencies
package fsfr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HDR_BYTE  = 8'h3E;
  localparam logic [7:0] BCAST     = 8'hFF;
  localparam logic [7:0] EV_DATA   = 8'h06;
  localparam logic [7:0] EV_LIMITS = 8'h07;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] ADDR_RST  = 8'h01;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_BAD_EV   = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_LIMITS = 1'b1;

  localparam logic [3:0] POS_HDR     = 4'd0;
  localparam logic [3:0] POS_ADDR    = 4'd1;
  localparam logic [3:0] POS_EVENT   = 4'd2;
  localparam logic [3:0] POS_TEMP    = 4'd3;
  localparam logic [3:0] POS_FUEL_LO = 4'd4;
  localparam logic [3:0] POS_FUEL_HI = 4'd5;
  localparam logic [3:0] POS_FREQ_HI = 4'd6;
  localparam logic [3:0] POS_FREQ_LO = 4'd7;
  localparam logic [3:0] POS_MAX_LO  = 4'd3;
  localparam logic [3:0] POS_MAX_HI  = 4'd4;
  localparam logic [3:0] POS_MIN_LO  = 4'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       hdr_ok;
    logic       ev_data;
    logic       ev_limits;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        frame_kind;
    logic [7:0]  responder_address;
    logic [7:0]  temperature;
    logic [15:0] fuel_value;
    logic [15:0] frequency;
    logic        crc_ok;
    logic [15:0] level_max;
    logic [15:0] level_min;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t err_result(input logic [1:0] st, input logic [7:0] addr);
    result_t r;
    r = '0;
    r.status = st;
    r.responder_address = addr;
    return r;
  endfunction

endpackage

FILE: rtl/core/fuel_sensor_frame_receiver.sv
// top level of the fuel sensor response frame receiver
// depends on fsfr_pkg, fsfr_front, fsfr_queue and fsfr_back
//
// usage:
//   in channel (in_valid_i/in_ready_o) carries one received byte per transaction,
//   with frame_start_i high on the first byte of a frame.
//   cfg channel (cfg_valid_i/cfg_ready_o) writes station_address; always ready,
//   write only while no frame is in flight.
//   out channel (out_valid_o/out_ready_i) gives one result per finished or
//   rejected frame; bytes that finish nothing give no transaction.
// throughput: one byte per cycle if no result is held (parse and crc combinational).
// path: a byte is written into the queue at its transaction, is parsed when it is
//   popped, and its result is then held in the result register until taken.
// reset: queue empty, no frame open, no result pending, station_address = 1.
// stall: a held result blocks the parse stage, the queue then fills and
//   in_ready_o drops once QDepth bytes are waiting.
module fuel_sensor_frame_receiver
  import fsfr_pkg::*;
#(
  parameter int unsigned QDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        frame_kind_o,
  output logic [7:0]  responder_address_o,
  output logic [7:0]  temperature_o,
  output logic [15:0] fuel_value_o,
  output logic [15:0] frequency_o,
  output logic        crc_ok_o,
  output logic [15:0] level_max_o,
  output logic [15:0] level_min_o
);

  logic [7:0] station_q;
  logic       q_full, q_push, q_pop, q_valid;
  entry_t     push_entry, pop_entry;
  result_t    result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= ADDR_RST;
    end else if (cfg_valid_i) begin
      station_q <= cfg_data_i;
    end
  end

  fsfr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .entry_o       (push_entry)
  );

  fsfr_queue #(
    .Width ($bits(entry_t)),
    .Depth (QDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (push_entry),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (pop_entry)
  );

  fsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .station_i   (station_q),
    .q_valid_i   (q_valid),
    .entry_i     (pop_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o            = result.status;
  assign frame_kind_o        = result.frame_kind;
  assign responder_address_o = result.responder_address;
  assign temperature_o       = result.temperature;
  assign fuel_value_o        = result.fuel_value;
  assign frequency_o         = result.frequency;
  assign crc_ok_o            = result.crc_ok;
  assign level_max_o         = result.level_max;
  assign level_min_o         = result.level_min;

endmodule

FILE: rtl/core/fsfr_queue.sv
// short register queue between the front and back parts
// generic width and depth, no package dependency
module fsfr_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

FILE: rtl/core/fsfr_front.sv
// front part: takes received bytes and classifies header and event codes
// depends on fsfr_pkg
module fsfr_front
  import fsfr_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.data      = data_byte_i;
    entry_o.start     = frame_start_i;
    entry_o.hdr_ok    = (data_byte_i == HDR_BYTE);
    entry_o.ev_data   = (data_byte_i == EV_DATA);
    entry_o.ev_limits = (data_byte_i == EV_LIMITS);
  end

endmodule

FILE: rtl/core/fsfr_back.sv
// back part: frame parsing, running crc and the result register
// depends on fsfr_pkg
module fsfr_back
  import fsfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] station_i,
  input  logic       q_valid_i,
  input  entry_t     entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    result_o
);

  logic        active_q, active_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic        kind_q, kind_d;
  logic [7:0]  addr_q, addr_d;
  logic [15:0] f0_q, f0_d, f1_q, f1_d, f2_q, f2_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d, res_n;
  logic        emit;

  logic        e_act, e_kind;
  logic [3:0]  e_pos;
  logic [7:0]  e_crc, e_addr, b;
  logic [15:0] e_f0, e_f1, e_f2;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign b      = entry_i.data;
  assign e_act  = entry_i.start || active_q;
  assign e_pos  = entry_i.start ? '0 : pos_q;
  assign e_crc  = entry_i.start ? '0 : crc_q;
  assign e_kind = entry_i.start ? KIND_DATA : kind_q;
  assign e_addr = entry_i.start ? '0 : addr_q;
  assign e_f0   = entry_i.start ? '0 : f0_q;
  assign e_f1   = entry_i.start ? '0 : f1_q;
  assign e_f2   = entry_i.start ? '0 : f2_q;

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    kind_d   = kind_q;
    addr_d   = addr_q;
    f0_d     = f0_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    res_n    = '0;
    emit     = 1'b0;
    if (pop_o && e_act) begin
      active_d = 1'b1;
      kind_d   = e_kind;
      addr_d   = e_addr;
      f0_d     = e_f0;
      f1_d     = e_f1;
      f2_d     = e_f2;
      crc_d    = crc8_update(e_crc, b);
      pos_d    = e_pos + 4'd1;
      case (e_pos)
        POS_HDR: begin
          if (!entry_i.hdr_ok) begin
            res_n = err_result(ST_BAD_HDR, 8'h00);
            emit  = 1'b1;
          end
        end
        POS_ADDR: addr_d = b;
        POS_EVENT: begin
          if (station_i != BCAST && e_addr != station_i) begin
            res_n = err_result(ST_BAD_ADDR, e_addr);
            emit  = 1'b1;
          end else if (entry_i.ev_data) begin
            kind_d = KIND_DATA;
          end else if (entry_i.ev_limits) begin
            if (e_addr != station_i) begin
              res_n = err_result(ST_BAD_ADDR, e_addr);
              emit  = 1'b1;
            end else begin
              kind_d = KIND_LIMITS;
            end
          end else begin
            res_n = err_result(ST_BAD_EV, e_addr);
            emit  = 1'b1;
          end
        end
        default: begin
          if (e_kind == KIND_DATA) begin
            case (e_pos)
              POS_TEMP:    f0_d = {8'h00, b};
              POS_FUEL_LO: f1_d = {8'h00, b};
              POS_FUEL_HI: f1_d = {b, e_f1[7:0]};
              POS_FREQ_HI: f2_d = {b, 8'h00};
              POS_FREQ_LO: f2_d = {e_f2[15:8], b};
              default: begin
                res_n.responder_address = e_addr;
                res_n.temperature       = e_f0[7:0];
                res_n.fuel_value        = e_f1;
                res_n.frequency         = e_f2;
                res_n.crc_ok            = (b == e_crc);
                emit                    = 1'b1;
              end
            endcase
          end else begin
            case (e_pos)
              POS_MAX_LO: f0_d = {8'h00, b};
              POS_MAX_HI: f0_d = {b, e_f0[7:0]};
              POS_MIN_LO: f1_d = {8'h00, b};
              default: begin
                f1_d                    = {b, e_f1[7:0]};
                res_n.frame_kind        = KIND_LIMITS;
                res_n.responder_address = e_addr;
                res_n.level_max         = e_f0;
                res_n.level_min         = {b, e_f1[7:0]};
                emit                    = 1'b1;
              end
            endcase
          end
        end
      endcase
      if (emit) begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (pop_o) begin
      out_valid_d = emit;
      if (emit) begin
        res_d = res_n;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      crc_q       <= '0;
      kind_q      <= KIND_DATA;
      addr_q      <= '0;
      f0_q        <= '0;
      f1_q        <= '0;
      f2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      kind_q      <= kind_d;
      addr_q      <= addr_d;
      f0_q        <= f0_d;
      f1_q        <= f1_d;
      f2_q        <= f2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_close_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit) |=> (!active_q && out_valid_q))
    else $error("frame still open after its result");
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != ST_OK) |-> (res_q.frame_kind == KIND_DATA))
    else $error("error result marked as limits frame");
  a_hdr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_BAD_HDR) |-> (res_q.responder_address == 8'h00))
    else $error("bad header result carries an address");
  a_no_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("pop from empty queue");
`endif

endmodule
